// ===== src/prq_pkg.sv =====
package prq_pkg;

  // Sizing of the scheduler
  localparam int THREADS = 8;
  localparam int LEVELS  = 16;

  // Fixed field widths of the channels
  localparam int TID_W = 3;
  localparam int LVL_W = 4;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  // Internal index widths
  localparam int THR_W = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int LVS_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LNK_W = $clog2(THREADS + 1);

  typedef logic [THR_W-1:0] thr_t;
  typedef logic [LVS_W-1:0] lvs_t;
  typedef logic [LNK_W-1:0] lnk_t;

  // Link code that marks the end of a FIFO
  localparam lnk_t LINK_NULL = LNK_W'(THREADS);

  typedef enum logic [OP_W-1:0] {
    OP_PUT  = 2'd0,
    OP_TAKE = 2'd1,
    OP_PICK = 2'd2,
    OP_SET  = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_SAME     = 2'd1,
    ST_NONE     = 2'd2,
    ST_NOT_HEAD = 2'd3
  } status_t;

  typedef struct packed {
    op_t              operation;
    logic [TID_W-1:0] thread_id;
    logic [LVL_W-1:0] level;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [TID_W-1:0] chosen_thread;
    logic             chosen_valid;
  } rsp_t;

  typedef struct packed {
    logic found;
    lvs_t idx;
  } pick_t;

endpackage

// ===== src/prq_if.sv =====
interface prq_req_if
  import prq_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [TID_W-1:0] thread_id;
  logic [LVL_W-1:0] level;

  modport source (output valid, operation, thread_id, level, input ready);
  modport sink   (input valid, operation, thread_id, level, output ready);
endinterface

interface prq_rsp_if
  import prq_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [TID_W-1:0] chosen_thread;
  logic             chosen_valid;

  modport source (output valid, status, chosen_thread, chosen_valid, input ready);
  modport sink   (input valid, status, chosen_thread, chosen_valid, output ready);
endinterface

// ===== src/priority_ready_queue_scheduler.sv =====
// Ready-queue scheduler: one FIFO of thread numbers per priority level.
// Request channel (req): operation put, take, pick or set priority, with a
// thread number and a level. Response channel (rsp): one transaction per
// request, carrying a status, the picked thread and its valid flag.
// Both channels use a valid/ready handshake; a transaction moves at a clock
// edge where both are high.
// An accepted request waits in the input register and executes into the
// response register, which presents it on rsp.
// Throughput: one request per cycle while the receiver does not stall, set by
// the single execute stage that reads and updates the level and thread state
// together.
// Requests are executed strictly in order, so each sees all earlier updates.
// When the receiver stalls, the response register holds its transaction,
// the input register holds one more request, and then req.ready drops.
// Reset (rst, synchronous): all FIFOs empty, no thread ready, all levels
// zero, both registers empty.
module priority_ready_queue_scheduler
  import prq_pkg::*;
  (
  input logic         clk,
  input logic         rst,
  prq_req_if.sink     req,
  prq_rsp_if.source   rsp
);

  logic req_valid_q;
  req_t req_q;
  logic rsp_valid_q;
  rsp_t rsp_q;
  rsp_t rsp_next;
  logic fire;

  // Execute when a request waits and the response slot is free or draining
  assign fire      = req_valid_q && (!rsp_valid_q || rsp.ready);
  assign req.ready = !req_valid_q || fire;

  prq_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .req  (req_q),
    .rsp  (rsp_next)
  );

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid_q <= 1'b0;
    end else if (req.ready) begin
      req_valid_q <= req.valid;
    end
    if (req.valid && req.ready) begin
      req_q.operation <= op_t'(req.operation);
      req_q.thread_id <= req.thread_id;
      req_q.level     <= req.level;
    end
  end

  // Hold the response until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_q <= 1'b0;
    end else if (fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
    if (fire) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid         = rsp_valid_q;
  assign rsp.status        = rsp_q.status;
  assign rsp.chosen_thread = rsp_q.chosen_thread;
  assign rsp.chosen_valid  = rsp_q.chosen_valid;

endmodule

// ===== src/prq_pick.sv =====
module prq_pick
  import prq_pkg::*;
  (
  input  logic [LEVELS-1:0] nonempty,
  output pick_t             pick
);

  // Find the lowest-numbered non-empty level
  always_comb begin
    pick.found = 1'b0;
    pick.idx   = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty[i]) begin
        pick.found = 1'b1;
        pick.idx   = LVS_W'(i);
      end
    end
  end

endmodule

// ===== src/prq_core.sv =====
module prq_core
  import prq_pkg::*;
  (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  req_t req,
  output rsp_t rsp
);

  // Scheduler state
  thr_t              queue_head [LEVELS];
  thr_t              queue_tail [LEVELS];
  logic [LEVELS-1:0] queue_nonempty;
  lnk_t              link_next [THREADS];
  logic [THREADS-1:0] ready_mark;
  logic [THREADS-1:0] head_mark;
  lvs_t              thread_level [THREADS];

  thr_t              queue_head_next [LEVELS];
  thr_t              queue_tail_next [LEVELS];
  logic [LEVELS-1:0] queue_nonempty_next;
  lnk_t              link_next_next [THREADS];
  logic [THREADS-1:0] ready_mark_next;
  logic [THREADS-1:0] head_mark_next;
  lvs_t              thread_level_next [THREADS];

  pick_t pick;
  thr_t  tid;
  lvs_t  lv;
  lvs_t  new_lv;
  lnk_t  nx;
  logic  tid_ok;

  prq_pick u_pick (
    .nonempty (queue_nonempty),
    .pick     (pick)
  );

  assign tid    = THR_W'(req.thread_id);
  assign tid_ok = int'(req.thread_id) < THREADS;
  assign lv     = thread_level[tid];
  assign nx     = link_next[tid];
  assign new_lv = (int'(req.level) >= LEVELS) ? LVS_W'(LEVELS - 1) : LVS_W'(req.level);

  // Execute one operation against the current state
  always_comb begin
    queue_head_next     = queue_head;
    queue_tail_next     = queue_tail;
    queue_nonempty_next = queue_nonempty;
    link_next_next      = link_next;
    ready_mark_next     = ready_mark;
    head_mark_next      = head_mark;
    thread_level_next   = thread_level;
    rsp.status          = ST_OK;
    rsp.chosen_thread   = '0;
    rsp.chosen_valid    = 1'b0;

    if (req.operation == OP_PICK) begin
      if (pick.found) begin
        rsp.chosen_thread = TID_W'(queue_head[pick.idx]);
        rsp.chosen_valid  = 1'b1;
      end else begin
        rsp.status = ST_NONE;
      end
    end else if (!tid_ok) begin
      rsp.status = ST_SAME;
    end else begin
      unique case (req.operation)
        OP_PUT: begin
          if (ready_mark[tid]) begin
            rsp.status = ST_SAME;
          end else begin
            // Append to the tail of the thread's level
            if (queue_nonempty[lv]) begin
              link_next_next[queue_tail[lv]] = LNK_W'(tid);
            end else begin
              queue_head_next[lv] = tid;
              head_mark_next[tid] = 1'b1;
            end
            queue_tail_next[lv]     = tid;
            queue_nonempty_next[lv] = 1'b1;
            link_next_next[tid]     = LINK_NULL;
            ready_mark_next[tid]    = 1'b1;
          end
        end
        OP_TAKE: begin
          if (!ready_mark[tid]) begin
            rsp.status = ST_SAME;
          end else if (!head_mark[tid]) begin
            rsp.status = ST_NOT_HEAD;
          end else begin
            // Advance the head, or empty the level at the last thread
            if (int'(nx) < THREADS) begin
              queue_head_next[lv]        = THR_W'(nx);
              head_mark_next[THR_W'(nx)] = 1'b1;
            end else begin
              queue_head_next[lv]     = '0;
              queue_tail_next[lv]     = '0;
              queue_nonempty_next[lv] = 1'b0;
            end
            head_mark_next[tid]  = 1'b0;
            ready_mark_next[tid] = 1'b0;
            link_next_next[tid]  = LINK_NULL;
          end
        end
        OP_SET: begin
          if (ready_mark[tid]) begin
            rsp.status = ST_SAME;
          end else begin
            thread_level_next[tid] = new_lv;
          end
        end
        default: begin
          rsp.status = ST_OK;
        end
      endcase
    end
  end

  // Commit the state on each executed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        queue_head[i] <= '0;
        queue_tail[i] <= '0;
      end
      for (int i = 0; i < THREADS; i++) begin
        link_next[i]    <= LINK_NULL;
        thread_level[i] <= '0;
      end
      queue_nonempty <= '0;
      ready_mark     <= '0;
      head_mark      <= '0;
    end else if (fire) begin
      queue_head     <= queue_head_next;
      queue_tail     <= queue_tail_next;
      queue_nonempty <= queue_nonempty_next;
      link_next      <= link_next_next;
      ready_mark     <= ready_mark_next;
      head_mark      <= head_mark_next;
      thread_level   <= thread_level_next;
    end
  end

endmodule
